### rtl/core/rsdf_pkg.sv
// Shared types and constants for the byte-serial response stream deframer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package rsdf_pkg;

   // sizing
   localparam int MAX_DEPTH = 8;
   localparam int LEN_BITS  = 32;
   localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   // result field widths
   localparam int KIND_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int NUM_W   = 64;
   localparam int NEST_W  = 4;
   localparam int ERR_W   = 3;

   // largest accepted bulk/array length
   localparam logic [NUM_W-1:0] LEN_LIMIT = (64'd1 << LEN_BITS) - 64'd1;

   // command from the parser to the count stack
   typedef struct packed {
      logic                push;
      logic                finish;
      logic                clear;
      logic [LEN_BITS-1:0] push_count;
   } stk_cmd_type;

   // status back from the count stack
   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic             full;
      logic             fin_msg;   // finishing now would end the message
   } stk_stat_type;

   // one result beat
   typedef struct packed {
      logic [KIND_W-1:0]        elem_type;
      logic [BYTE_W-1:0]        payload_byte;
      logic                     payload_valid;
      logic                     elem_done;
      logic signed [NUM_W-1:0]  number_value;
      logic                     is_null;
      logic                     message_done;
      logic [NEST_W-1:0]        nest_depth;
      logic [ERR_W-1:0]         error_code;
   } rsp_beat_type;

endpackage

### rtl/core/rsdf_if.sv
// Stream channel interfaces: raw byte input and deframed result output.
// Depends on rsdf_pkg for field widths.
`timescale 1ns / 1ps

interface rsdf_req_if import rsdf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface rsdf_rsp_if import rsdf_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       elem_type;
   logic [BYTE_W-1:0]       payload_byte;
   logic                    payload_valid;
   logic                    elem_done;
   logic signed [NUM_W-1:0] number_value;
   logic                    is_null;
   logic                    message_done;
   logic [NEST_W-1:0]       nest_depth;
   logic [ERR_W-1:0]        error_code;

   modport source (output valid, output elem_type, output payload_byte,
                   output payload_valid, output elem_done, output number_value,
                   output is_null, output message_done, output nest_depth,
                   output error_code, input ready);
   modport sink   (input valid, input elem_type, input payload_byte,
                   input payload_valid, input elem_done, input number_value,
                   input is_null, input message_done, input nest_depth,
                   input error_code, output ready);
endinterface

### rtl/core/rsdf_count_stack.sv
// Array element-count stack whose finish pops all filled levels at once.
// Depends on rsdf_pkg.
`timescale 1ns / 1ps

module rsdf_count_stack import rsdf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  stk_cmd_type  cmd,
   output stk_stat_type stat
);

   logic [LEN_BITS-1:0] count_ff [MAX_DEPTH];
   logic                one_ff   [MAX_DEPTH];   // entry holds exactly one
   logic [LVL_W-1:0]    level_ff;

   logic             found;
   logic [IDX_W-1:0] tgt;
   logic [LVL_W-1:0] level_in;
   logic [LEN_BITS-1:0] tgt_count;

   // highest live level whose count is not about to hit zero
   always_comb begin
      found = 1'b0;
      tgt   = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if ((level_ff > LVL_W'(i)) && !one_ff[i]) begin
            found = 1'b1;
            tgt   = IDX_W'(i);
         end
      end
   end

   assign tgt_count = count_ff[tgt];

   always_comb begin
      level_in = level_ff;
      if (cmd.clear) begin
         level_in = '0;
      end else if (cmd.finish) begin
         level_in = found ? (LVL_W'(tgt) + LVL_W'(1)) : '0;
      end else if (cmd.push) begin
         level_in = level_ff + LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   // entries are only read below the level, so they need no reset
   always_ff @(posedge clock) begin
      if (!cmd.clear && cmd.finish && found) begin
         count_ff[tgt] <= tgt_count - LEN_BITS'(1);
         one_ff[tgt]   <= (tgt_count == LEN_BITS'(2));
      end else if (!cmd.clear && !cmd.finish && cmd.push) begin
         count_ff[level_ff[IDX_W-1:0]] <= cmd.push_count;
         one_ff[level_ff[IDX_W-1:0]]   <= (cmd.push_count == LEN_BITS'(1));
      end
   end

   assign stat.level   = level_ff;
   assign stat.full    = (level_ff >= LVL_W'(MAX_DEPTH));
   assign stat.fin_msg = !found;

endmodule

### rtl/core/rsdf_out_stage.sv
// Result register driving the output channel.
// Depends on rsdf_pkg and rsdf_rsp_if.
`timescale 1ns / 1ps

module rsdf_out_stage import rsdf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_beat_type beat,
   output logic         can_load,
   rsdf_rsp_if.source   rsp_chan
);

   logic         valid_ff;
   rsp_beat_type beat_ff;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.elem_type     = beat_ff.elem_type;
   assign rsp_chan.payload_byte  = beat_ff.payload_byte;
   assign rsp_chan.payload_valid = beat_ff.payload_valid;
   assign rsp_chan.elem_done     = beat_ff.elem_done;
   assign rsp_chan.number_value  = beat_ff.number_value;
   assign rsp_chan.is_null       = beat_ff.is_null;
   assign rsp_chan.message_done  = beat_ff.message_done;
   assign rsp_chan.nest_depth    = beat_ff.nest_depth;
   assign rsp_chan.error_code    = beat_ff.error_code;

endmodule

### rtl/core/resp_stream_deframer_unit.sv
// Top level of the byte-serial response stream deframer.
// Depends on rsdf_pkg, rsdf_if, rsdf_count_stack and rsdf_out_stage.
`timescale 1ns / 1ps

// Usage
//   req_chan : one raw protocol byte per beat (valid/ready).
//   rsp_chan : exactly one result beat per input beat, in order: element
//              kind, payload byte, element/message end marks, header value,
//              null mark, nesting depth and error code.
//   csr_wr_*: bulk_no_trailer, written while the block is idle; set for
//              replication sync bulks that carry no trailing CR LF.
// Path: a byte accepted into the input register is parsed combinationally;
//   its result beat is then loaded into the result register driving rsp_chan.
// Throughput: one byte per cycle while rsp_chan is ready; set by the single
//   parse step between the input register and the result register.
// Reset: expects a type byte, count stack empty, bulk_no_trailer cleared,
//   both registers empty. No clearing pass is needed.
// Stall: while rsp_chan is stalled one more byte is taken into the input
//   register; then req_chan.ready drops until the result is taken.
// Errors are flagged on the bad byte; the stack empties and, unless that
//   byte was LF, the bytes up to and including the next LF are dropped.

module resp_stream_deframer_unit import rsdf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rsdf_req_if.sink   req_chan,
   rsdf_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   // parse phases
   localparam logic [2:0] PH_TYPE     = 3'd0;
   localparam logic [2:0] PH_LINE     = 3'd1;
   localparam logic [2:0] PH_NUM      = 3'd2;
   localparam logic [2:0] PH_HDR_LF   = 3'd3;
   localparam logic [2:0] PH_BULK     = 3'd4;
   localparam logic [2:0] PH_TRAIL_CR = 3'd5;
   localparam logic [2:0] PH_END_LF   = 3'd6;
   localparam logic [2:0] PH_SKIP     = 3'd7;

   // element kinds
   localparam logic [KIND_W-1:0] K_SIMPLE = 3'd0;
   localparam logic [KIND_W-1:0] K_ERROR  = 3'd1;
   localparam logic [KIND_W-1:0] K_INT    = 3'd2;
   localparam logic [KIND_W-1:0] K_BULK   = 3'd3;
   localparam logic [KIND_W-1:0] K_ARRAY  = 3'd4;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
   localparam logic [ERR_W-1:0] ERR_TYPE  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_INT   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_LEN   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_DEEP  = 3'd4;

   // wire characters
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_BULK  = 8'h24;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [67:0] POS_LIM = 68'h0_7FFF_FFFF_FFFF_FFFF;
   localparam logic [67:0] NEG_LIM = 68'h0_8000_0000_0000_0000;

   // config
   logic cfg_no_trailer_ff;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // parser state
   logic [2:0]          phase_ff,  phase_in;
   logic [KIND_W-1:0]   kind_ff,   kind_in;
   logic [NUM_W-1:0]    acc_ff,    acc_in;
   logic                neg_ff,    neg_in;
   logic                digit_ff,  digit_in;
   logic [LEN_BITS-1:0] left_ff,   left_in;

   logic         out_free;
   logic         advance;
   stk_cmd_type  cmd_c, stk_cmd;
   stk_stat_type stk_stat;
   rsp_beat_type beat_c;

   // per-byte decode
   logic [BYTE_W-1:0] b;
   logic              is_digit;
   logic [67:0]       acc_x10;
   logic [67:0]       lim;
   logic              fin;
   logic [ERR_W-1:0]  err;

   assign advance       = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_no_trailer_ff <= 1'b0;
      end else if (csr_wr_en) begin
         cfg_no_trailer_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
      end
   end

   assign b        = in_byte_ff;
   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   // accum * 10 + digit, wide enough to never wrap
   assign acc_x10  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                     + {64'd0, b[3:0]};
   assign lim      = neg_ff ? NEG_LIM : POS_LIM;

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      digit_in = digit_ff;
      left_in  = left_ff;
      fin      = 1'b0;
      err      = ERR_OK;
      cmd_c    = '0;
      beat_c   = '0;

      case (phase_ff)
         PH_TYPE: begin
            acc_in   = '0;
            neg_in   = 1'b0;
            digit_in = 1'b0;
            phase_in = PH_NUM;
            if (b == CH_PLUS) begin
               kind_in  = K_SIMPLE;
               phase_in = PH_LINE;
            end else if (b == CH_MINUS) begin
               kind_in  = K_ERROR;
               phase_in = PH_LINE;
            end else if (b == CH_COLON) begin
               kind_in = K_INT;
            end else if (b == CH_BULK) begin
               kind_in = K_BULK;
            end else if (b == CH_STAR) begin
               kind_in = K_ARRAY;
            end else begin
               kind_in = K_SIMPLE;
               err     = ERR_TYPE;
            end
         end
         PH_LINE: begin
            if (b == CH_CR) begin
               phase_in = PH_END_LF;
            end else begin
               beat_c.payload_byte  = b;
               beat_c.payload_valid = 1'b1;
            end
         end
         PH_NUM: begin
            if (is_digit) begin
               if (acc_x10 > lim) begin
                  err = ERR_INT;
               end else begin
                  acc_in   = acc_x10[NUM_W-1:0];
                  digit_in = 1'b1;
               end
            end else if (b == CH_MINUS && !digit_ff && !neg_ff) begin
               neg_in = 1'b1;
            end else if (b == CH_CR && digit_ff) begin
               // "-0" is plain zero
               if (acc_ff == '0) begin
                  neg_in = 1'b0;
               end
               if (kind_ff >= K_BULK &&
                   ((neg_ff && acc_ff != '0) ? (acc_ff != NUM_W'(1))
                                            : (acc_ff > LEN_LIMIT))) begin
                  err = ERR_LEN;
               end else begin
                  phase_in = PH_HDR_LF;
               end
            end else begin
               err = ERR_INT;
            end
         end
         PH_HDR_LF: begin
            if (b != CH_LF) begin
               err = ERR_INT;
            end else begin
               beat_c.number_value = neg_ff ? (NUM_W'(0) - acc_ff) : acc_ff;
               if (kind_ff == K_INT) begin
                  fin = 1'b1;
               end else if (neg_ff) begin
                  beat_c.is_null = 1'b1;
                  fin            = 1'b1;
               end else if (kind_ff == K_BULK) begin
                  if (acc_ff != '0) begin
                     left_in  = acc_ff[LEN_BITS-1:0];
                     phase_in = PH_BULK;
                  end else if (cfg_no_trailer_ff) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = PH_TRAIL_CR;
                  end
               end else if (acc_ff == '0) begin
                  fin = 1'b1;
               end else if (stk_stat.full) begin
                  beat_c.number_value = '0;
                  err                 = ERR_DEEP;
               end else begin
                  cmd_c.push       = 1'b1;
                  cmd_c.push_count = acc_ff[LEN_BITS-1:0];
                  beat_c.elem_done = 1'b1;
                  phase_in         = PH_TYPE;
               end
            end
         end
         PH_BULK: begin
            beat_c.payload_byte  = b;
            beat_c.payload_valid = 1'b1;
            left_in              = left_ff - LEN_BITS'(1);
            if (left_ff == LEN_BITS'(1)) begin
               if (cfg_no_trailer_ff) begin
                  fin = 1'b1;
               end else begin
                  phase_in = PH_TRAIL_CR;
               end
            end
         end
         PH_TRAIL_CR: begin
            if (b == CH_CR) begin
               phase_in = PH_END_LF;
            end else begin
               err = ERR_LEN;
            end
         end
         PH_END_LF: begin
            if (b == CH_LF) begin
               fin = 1'b1;
            end else begin
               err = ERR_LEN;
            end
         end
         default: begin
            // dropping bytes until the line ends
            if (b == CH_LF) begin
               phase_in = PH_TYPE;
            end
         end
      endcase

      if (fin) begin
         cmd_c.finish        = 1'b1;
         beat_c.elem_done    = 1'b1;
         beat_c.message_done = stk_stat.fin_msg;
         phase_in            = PH_TYPE;
      end
      if (err != ERR_OK) begin
         cmd_c.clear = 1'b1;
         phase_in    = (b == CH_LF) ? PH_TYPE : PH_SKIP;
      end

      beat_c.elem_type  = kind_in;
      beat_c.nest_depth = NEST_W'(stk_stat.level);
      beat_c.error_code = err;
   end

   // stack only moves on a byte that is really processed
   always_comb begin
      stk_cmd        = cmd_c;
      stk_cmd.push   = cmd_c.push   && advance;
      stk_cmd.finish = cmd_c.finish && advance;
      stk_cmd.clear  = cmd_c.clear  && advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         kind_ff  <= K_SIMPLE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         digit_ff <= 1'b0;
         left_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         digit_ff <= digit_in;
         left_ff  <= left_in;
      end
   end

   rsdf_count_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   rsdf_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .beat     (beat_c),
      .can_load (out_free),
      .rsp_chan (rsp_chan)
   );

   // an error beat never closes an element
   a_err_no_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.error_code != ERR_OK)
         |-> (!rsp_chan.elem_done && !rsp_chan.message_done))
      else $error("error beat marks an element end");

   // a message can only end where an element ends
   a_msg_elem: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.message_done) |-> rsp_chan.elem_done)
      else $error("message end without element end");

   // every error empties the count stack
   a_err_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && err != ERR_OK) |=> (stk_stat.level == '0))
      else $error("stack not empty after error");

   // a null header always reports minus one
   a_null_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_null) |-> (rsp_chan.number_value == -64'sd1))
      else $error("null header with value other than -1");

   // the depth never passes the stack size
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      stk_stat.level <= LVL_W'(MAX_DEPTH))
      else $error("nesting level beyond stack size");

endmodule

### dv/resp_stream_deframer_unit_test.sv
// Self-checking bench for resp_stream_deframer_unit: random and directed byte
// streams, a cycle-free predictor of the deframer and a scoreboard of beats.
// Depends on rsdf_pkg, rsdf_if and the deframer RTL.
`timescale 1ns / 1ps

module resp_stream_deframer_unit_test;
   import rsdf_pkg::*;

   // protocol bytes
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_MINUS    = "-";
   localparam logic [7:0] TYPE_SIMPLE = "+";
   localparam logic [7:0] TYPE_ERROR  = "-";
   localparam logic [7:0] TYPE_INT    = ":";
   localparam logic [7:0] TYPE_BULK   = "$";
   localparam logic [7:0] TYPE_ARRAY  = "*";

   localparam int LONG_HOLD   = 80;    // receiver hold-off, cycles
   localparam int STALL_LIMIT = 2000;  // cycles with no beat on either side
   localparam int PRINT_CAP   = 30;

   typedef enum logic [2:0] {
      ELEM_SIMPLE, ELEM_ERROR, ELEM_INT, ELEM_BULK, ELEM_ARRAY
   } elem_kind_type;

   typedef enum logic [2:0] {
      CODE_OK, CODE_TYPE, CODE_NUMBER, CODE_LENGTH, CODE_DEPTH
   } err_code_type;

   typedef enum logic [2:0] {
      AWAIT_TYPE, IN_LINE, IN_NUMBER, HEADER_LF, IN_BULK, TRAILER_CR, TRAILER_LF, DROP_LINE
   } rx_phase_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   rsdf_req_if req_chan ();
   rsdf_rsp_if rsp_chan ();

   resp_stream_deframer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: mirrors the deframer after every accepted byte.
   // ---------------------------------------------------------------------
   logic          no_trailer = 1'b0;      // shadow of bulk_no_trailer
   rx_phase_type  rx_phase   = AWAIT_TYPE;
   elem_kind_type rx_kind    = ELEM_SIMPLE;
   logic [63:0]   num_mag    = '0;        // header magnitude, sign kept apart
   logic          num_neg    = 1'b0;
   logic          num_digit  = 1'b0;
   logic [63:0]   bulk_left  = '0;
   logic [63:0]   arr_left [MAX_DEPTH];   // children still owed per level
   int            arr_level  = 0;

   // Bench bookkeeping
   logic [7:0]   stream_bytes [$];        // bytes waiting for the driver
   rsp_beat_type expected_beats [$];      // predicted beats, oldest first
   int           queued_total = 0;
   int           mismatches   = 0;
   bit           idle_on      = 1'b1;     // random idling on both sides
   int           hold_requests = 0;       // bumped to ask for a long hold-off

   // Any error: stack empties; resync is immediate on LF, else drop to LF.
   function automatic err_code_type flag_error(input logic [7:0] b,
                                               input err_code_type code);
      arr_level = 0;
      if (b == CH_LF) rx_phase = AWAIT_TYPE;
      else rx_phase = DROP_LINE;
      return code;
   endfunction

   // Element ends: count it in the innermost open array; each array it completes
   // pops and counts in its parent. Returns 1 when nothing is open: message done.
   function automatic logic close_element();
      rx_phase = AWAIT_TYPE;
      while (arr_level > 0) begin
         arr_left[arr_level - 1] = arr_left[arr_level - 1] - 64'd1;
         if (arr_left[arr_level - 1] != 0) return 1'b0;
         arr_level = arr_level - 1;
      end
      return 1'b1;
   endfunction

   function automatic rsp_beat_type decode_byte(input logic [7:0] b);
      rsp_beat_type r;
      logic [63:0]  d;
      logic [63:0]  lim;
      r = '0;
      r.nest_depth = NEST_W'(arr_level);   // depth before this byte
      case (rx_phase)
         AWAIT_TYPE: begin
            num_mag   = '0;
            num_neg   = 1'b0;
            num_digit = 1'b0;
            rx_phase  = IN_NUMBER;
            case (b)
               TYPE_SIMPLE: begin
                  rx_kind  = ELEM_SIMPLE;
                  rx_phase = IN_LINE;
               end
               TYPE_ERROR: begin
                  rx_kind  = ELEM_ERROR;
                  rx_phase = IN_LINE;
               end
               TYPE_INT:   rx_kind = ELEM_INT;
               TYPE_BULK:  rx_kind = ELEM_BULK;
               TYPE_ARRAY: rx_kind = ELEM_ARRAY;
               default: begin
                  rx_kind      = ELEM_SIMPLE;
                  r.error_code = flag_error(b, CODE_TYPE);
               end
            endcase
         end
         IN_LINE: begin
            // a lone LF is just payload here
            if (b == CH_CR) rx_phase = TRAILER_LF;
            else begin
               r.payload_byte  = b;
               r.payload_valid = 1'b1;
            end
         end
         IN_NUMBER: begin
            if (b >= "0" && b <= "9") begin
               d   = 64'(b - "0");
               lim = num_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
               if (num_mag > (lim - d) / 64'd10) r.error_code = flag_error(b, CODE_NUMBER);
               else begin
                  num_mag   = num_mag * 64'd10 + d;
                  num_digit = 1'b1;
               end
            end else if (b == CH_MINUS && !num_digit && !num_neg) begin
               num_neg = 1'b1;
            end else if (b == CH_CR && num_digit) begin
               if (num_mag == 0) num_neg = 1'b0;   // minus zero is zero
               if (rx_kind >= ELEM_BULK &&
                   (num_neg ? (num_mag != 64'd1) : (num_mag > LEN_LIMIT)))
                  r.error_code = flag_error(b, CODE_LENGTH);
               else rx_phase = HEADER_LF;
            end else begin
               r.error_code = flag_error(b, CODE_NUMBER);
            end
         end
         HEADER_LF: begin
            if (b != CH_LF) r.error_code = flag_error(b, CODE_NUMBER);
            else begin
               r.number_value = num_neg ? -num_mag : num_mag;
               if (rx_kind == ELEM_INT || num_neg) begin
                  // a negative integer is a value, not a null
                  r.is_null      = num_neg && (rx_kind != ELEM_INT);
                  r.elem_done    = 1'b1;
                  r.message_done = close_element();
               end else if (rx_kind == ELEM_BULK) begin
                  if (num_mag != 0) begin
                     bulk_left = num_mag;
                     rx_phase  = IN_BULK;
                  end else if (no_trailer) begin
                     r.elem_done    = 1'b1;
                     r.message_done = close_element();
                  end else rx_phase = TRAILER_CR;
               end else if (num_mag == 0) begin
                  r.elem_done    = 1'b1;
                  r.message_done = close_element();
               end else if (arr_level >= MAX_DEPTH) begin
                  r.number_value = '0;
                  r.error_code   = flag_error(b, CODE_DEPTH);
               end else begin
                  // array header ends; its children come one level deeper
                  arr_left[arr_level] = num_mag;
                  arr_level           = arr_level + 1;
                  r.elem_done         = 1'b1;
                  rx_phase            = AWAIT_TYPE;
               end
            end
         end
         IN_BULK: begin
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            bulk_left       = bulk_left - 64'd1;
            if (bulk_left == 0) begin
               if (no_trailer) begin
                  r.elem_done    = 1'b1;
                  r.message_done = close_element();
               end else rx_phase = TRAILER_CR;
            end
         end
         TRAILER_CR: begin
            if (b == CH_CR) rx_phase = TRAILER_LF;
            else r.error_code = flag_error(b, CODE_LENGTH);
         end
         TRAILER_LF: begin
            if (b == CH_LF) begin
               r.elem_done    = 1'b1;
               r.message_done = close_element();
            end else r.error_code = flag_error(b, CODE_LENGTH);
         end
         default: begin
            if (b == CH_LF) rx_phase = AWAIT_TYPE;
         end
      endcase
      r.elem_type = rx_kind;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got)
         report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
   endtask

   task automatic check_beat();
      rsp_beat_type want;
      if (expected_beats.size() == 0) begin
         report_mismatch("result beat with nothing expected");
         return;
      end
      want = expected_beats[0];
      expected_beats.delete(0);
      compare_field("elem_type",     64'(want.elem_type),     64'(rsp_chan.elem_type));
      compare_field("payload_byte",  64'(want.payload_byte),  64'(rsp_chan.payload_byte));
      compare_field("payload_valid", 64'(want.payload_valid), 64'(rsp_chan.payload_valid));
      compare_field("elem_done",     64'(want.elem_done),     64'(rsp_chan.elem_done));
      compare_field("number_value",  want.number_value,       rsp_chan.number_value);
      compare_field("is_null",       64'(want.is_null),       64'(rsp_chan.is_null));
      compare_field("message_done",  64'(want.message_done),  64'(rsp_chan.message_done));
      compare_field("nest_depth",    64'(want.nest_depth),    64'(rsp_chan.nest_depth));
      compare_field("error_code",    64'(want.error_code),    64'(rsp_chan.error_code));
   endtask

   // ---------------------------------------------------------------------
   // Driver: one byte per beat from stream_bytes; the prediction is made
   // when the beat is taken. Random gaps between bytes while idle_on.
   // ---------------------------------------------------------------------
   int send_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.data_byte <= '0;
         send_gap           <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_beats.push_back(decode_byte(req_chan.data_byte));
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap       <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               send_gap       <= $urandom_range(0, 14);
               req_chan.valid <= 1'b0;
            end else if (stream_bytes.size() != 0) begin
               req_chan.valid     <= 1'b1;
               req_chan.data_byte <= stream_bytes[0];
               stream_bytes.delete(0);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: takes result beats, stalls at random, and applies the
   // LONG_HOLD hold-off whenever hold_requests moves on.
   // ---------------------------------------------------------------------
   int stall_left;
   int holds_seen;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
         holds_seen     <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_beat();
         if (holds_seen != hold_requests) begin
            holds_seen     <= hold_requests;
            stall_left     <= LONG_HOLD - 1;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left     <= stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left     <= $urandom_range(0, 14);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without a beat on either channel means a hang.
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------------
   // Stream builders
   // ---------------------------------------------------------------------
   task automatic put(input logic [7:0] b);
      stream_bytes.push_back(b);
      queued_total++;
   endtask

   task automatic put_text(input string s);
      foreach (s[i]) put(s[i]);
   endtask

   task automatic put_crlf();
      put(CH_CR);
      put(CH_LF);
   endtask

   task automatic put_header(input logic [7:0] t, input logic neg, input logic [63:0] mag);
      logic [7:0] digits [$];
      put(t);
      if (neg) put(CH_MINUS);
      if (mag == 0) digits.push_back("0");
      while (mag != 0) begin
         digits.insert(0, "0" + 8'(mag % 64'd10));
         mag = mag / 64'd10;
      end
      foreach (digits[i]) put(digits[i]);
      put_crlf();
   endtask

   // Line payload: anything but CR, with LF now and then.
   function automatic logic [7:0] line_byte();
      logic [7:0] b;
      if ($urandom_range(0, 7) == 0) return CH_LF;
      do b = 8'($urandom); while (b == CH_CR);
      return b;
   endfunction

   // One well-formed element; arrays recurse, mostly shallow and small.
   task automatic gen_element(input int depth);
      int          pick;
      int          len;
      int          small_val;
      logic [63:0] v;
      pick = $urandom_range(0, 9);
      if (pick >= 7 && depth < 4) begin
         if ($urandom_range(0, 9) == 0) put_header(TYPE_ARRAY, 1'b1, 64'd1);
         else begin
            len = $urandom_range(0, (depth == 0) ? 3 : 2);
            put_header(TYPE_ARRAY, 1'b0, 64'(len));
            repeat (len) gen_element(depth + 1);
         end
      end else if (pick <= 1) begin
         put((pick == 0) ? TYPE_SIMPLE : TYPE_ERROR);
         len = $urandom_range(0, 8);
         repeat (len) put(line_byte());
         put_crlf();
      end else if (pick <= 3) begin
         small_val = $urandom_range(0, 2000) - 1000;
         if ($urandom_range(0, 2) == 0) v = {$urandom, $urandom};
         else v = 64'(small_val);
         put_header(TYPE_INT, v[63], v[63] ? -v : v);
      end else begin
         if ($urandom_range(0, 9) == 0) put_header(TYPE_BULK, 1'b1, 64'd1);
         else begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            put_header(TYPE_BULK, 1'b0, 64'(len));
            repeat (len) put(8'($urandom));
            if (!no_trailer) put_crlf();
         end
      end
   endtask

   // Mostly well-formed messages; the rest are noise, corrupted or cut-off
   // messages, and deep chains of single-child arrays (some one too deep).
   task automatic gen_random(input int n_bytes);
      int goal;
      int start;
      int pick;
      int cut;
      goal = queued_total + n_bytes;
      while (queued_total < goal) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            repeat ($urandom_range(1, 5)) put(8'($urandom));
            put(CH_LF);
         end else if (pick <= 2) begin
            start = stream_bytes.size();
            gen_element(0);
            if (pick == 1)
               stream_bytes[$urandom_range(start, stream_bytes.size() - 1)] = 8'($urandom);
            else begin
               // keep the type byte, cut somewhere in the rest
               cut = $urandom_range(start + 1, stream_bytes.size() - 1);
               while (stream_bytes.size() > cut) begin
                  void'(stream_bytes.pop_back());
                  queued_total--;
               end
            end
            put(CH_LF);
         end else if (pick == 3) begin
            repeat ($urandom_range(5, MAX_DEPTH + 1)) put_header(TYPE_ARRAY, 1'b0, 64'd1);
            gen_element(MAX_DEPTH);
         end else begin
            gen_element(0);
         end
      end
   endtask

   // Sender pause: wait for every byte to be taken and every beat checked.
   task automatic drain_stream();
      do @(posedge clock);
      while (stream_bytes.size() != 0 || req_chan.valid || expected_beats.size() != 0);
      repeat (2) @(posedge clock);
      @(negedge clock);
   endtask

   // bulk_no_trailer is only written with the block idle.
   task automatic write_cfg(input logic v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      no_trailer   = v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed, trailer on ---
      write_cfg(1'b0);
      put_text("+OK");               put_crlf();
      put_text("-E"); put(CH_LF);    put_text("R"); put_crlf();   // LF inside a line
      put_header(TYPE_INT, 1'b0, 64'd0);
      put_header(TYPE_INT, 1'b1, 64'd0);                         // minus zero
      put_text(":007");              put_crlf();
      put_header(TYPE_INT, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
      put_header(TYPE_INT, 1'b1, 64'h8000_0000_0000_0000);
      put_header(TYPE_INT, 1'b0, 64'h8000_0000_0000_0000);       // overflow
      put_text(":-9223372036854775809"); put_crlf();             // overflow
      put_text(":+5");               put_crlf();                 // plus sign refused
      put_text(":5-");               put_crlf();                 // sign not first
      put_text(":");                 put_crlf();                 // CR, no digit
      put_text(":-");                put_crlf();
      put_text(":"); put(CH_LF);                                 // bad byte is LF
      put_text(":5"); put(CH_CR); put(CH_CR); put(CH_LF);        // header CR then not LF
      put_header(TYPE_BULK, 1'b0, 64'd3); put_text("abc"); put_crlf();
      put_header(TYPE_BULK, 1'b0, 64'd0); put_crlf();
      put_header(TYPE_BULK, 1'b0, 64'd4); put_crlf(); put_crlf(); put_crlf();
      put_header(TYPE_BULK, 1'b1, 64'd1);                        // null bulk
      put_header(TYPE_ARRAY, 1'b1, 64'd1);                       // null array
      put_header(TYPE_ARRAY, 1'b0, 64'd0);
      put_header(TYPE_BULK, 1'b1, 64'd2);                        // length below -1
      put_header(TYPE_BULK, 1'b0, 64'h1_0000_0000);              // length too long
      put_header(TYPE_ARRAY, 1'b0, 64'hFFFF_FFFF);               // largest count...
      put_text("x"); put(CH_LF);                                 // ...cut by a bad type
      put_text("+ab"); put(CH_CR); put_text("X"); put(CH_LF);    // broken line end
      put_header(TYPE_BULK, 1'b0, 64'd2); put_text("abXY"); put(CH_LF);
      put_header(TYPE_BULK, 1'b0, 64'd2); put_text("ab"); put(CH_CR); put_text("Y"); put(CH_LF);
      put(CH_CR); put(CH_LF); put(CH_LF); put(8'hFF); put(CH_LF); put(8'h00); put(CH_LF);
      put_header(TYPE_ARRAY, 1'b0, 64'd2);
      put_header(TYPE_INT, 1'b0, 64'd1);
      put_header(TYPE_ARRAY, 1'b0, 64'd1);
      put_header(TYPE_BULK, 1'b0, 64'd1); put_text("z"); put_crlf();
      repeat (MAX_DEPTH + 1) put_header(TYPE_ARRAY, 1'b0, 64'd1);   // one too deep
      repeat (MAX_DEPTH) put_header(TYPE_ARRAY, 1'b0, 64'd1);       // deepest legal
      put_header(TYPE_INT, 1'b0, 64'd5);
      drain_stream();

      // --- directed, no bulk trailer ---
      write_cfg(1'b1);
      put_header(TYPE_BULK, 1'b0, 64'd3); put_text("abc");
      put_header(TYPE_BULK, 1'b0, 64'd0);
      put_header(TYPE_BULK, 1'b1, 64'd1);
      put_header(TYPE_ARRAY, 1'b0, 64'd2);
      put_header(TYPE_BULK, 1'b0, 64'd1); put_text("q");
      put_header(TYPE_BULK, 1'b0, 64'd2); put_crlf();
      drain_stream();

      // --- back-pressure: receiver holds off while the sender keeps going ---
      write_cfg(1'b0);
      hold_requests = hold_requests + 1;
      gen_random(10);
      drain_stream();

      // --- random phases, both trailer settings, random idling ---
      for (int p = 0; p < 4; p++) begin
         write_cfg(p[0] ? 1'b0 : 1'b1);
         gen_random(8);
         drain_stream();
      end

      // --- closing stretch at full rate ---
      idle_on = 1'b0;
      write_cfg(1'b0);
      gen_random(10);
      drain_stream();

      if (expected_beats.size() != 0) report_mismatch("beats still expected at the end");
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

### resp_stream_deframer_unit.f
rtl/core/rsdf_pkg.sv
rtl/core/rsdf_if.sv
rtl/core/rsdf_count_stack.sv
rtl/core/rsdf_out_stage.sv
rtl/core/resp_stream_deframer_unit.sv
dv/resp_stream_deframer_unit_test.sv
